FILE: rtl/csq_pkg.sv
// csq_pkg: shared constants, codes and handshake structs of the semaphore wait queue
// used by csq_ctrl, csq_datapath and counting_semaphore_wait_queue; no dependencies
`default_nettype none

package csq_pkg;

    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int THREAD_ID_BITS_DEF = 8;

    localparam int OP_W      = 2;
    localparam int TID_W     = 8;
    localparam int KIND_W    = 3;
    localparam int CFG_W     = 15;
    localparam int COUNT_W   = 16;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic [OP_W-1:0] OP_WAIT   = 2'd0;
    localparam logic [OP_W-1:0] OP_SIGNAL = 2'd1;
    localparam logic [OP_W-1:0] OP_CLOSE  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_GRANTED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BLOCKED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SIG_DONE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLOSED   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd5;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = -16'sh8000;

    typedef struct packed {
        logic load_in;
        logic do_op;
        logic drain_pop;
        logic close_done;
    } csq_cmd_t;

    typedef struct packed {
        logic            out_free;
        logic            queue_empty;
        logic [OP_W-1:0] op;
    } csq_sts_t;

endpackage

`default_nettype wire

FILE: rtl/csq_ctrl.sv
// csq_ctrl: sequencing state machine of the semaphore wait queue
// depends on csq_pkg; drives csq_datapath through csq_cmd_t and reads csq_sts_t
`default_nettype none

module csq_ctrl
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  csq_pkg::csq_sts_t sts,
    output csq_pkg::csq_cmd_t cmd
);

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DRAIN} state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (sts.op) inside
                    csq_pkg::OP_WAIT, csq_pkg::OP_SIGNAL:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.do_op  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    csq_pkg::OP_CLOSE:
                    begin
                        state_next = ST_DRAIN;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DRAIN:
            begin
                if (sts.out_free)
                begin
                    if (sts.queue_empty)
                    begin
                        cmd.close_done = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        cmd.drain_pop = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/csq_datapath.sv
// csq_datapath: count, waiter fifo memory, input latch and output beat register
// depends on csq_pkg; commanded by csq_ctrl
`default_nettype none

module csq_datapath
#(
    parameter int QUEUE_DEPTH    = csq_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = csq_pkg::THREAD_ID_BITS_DEF
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire  [csq_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire  [csq_pkg::OP_W-1:0]         in_op,
    input  wire  [csq_pkg::TID_W-1:0]        in_tid,
    input  wire                              m_tready,
    output logic                             m_tvalid,
    output logic [csq_pkg::KIND_W-1:0]       out_kind,
    output logic [csq_pkg::TID_W-1:0]        out_tid,
    output logic                             out_woke,
    output logic                             out_failed,
    output logic                             out_last,
    input  csq_pkg::csq_cmd_t                cmd,
    output csq_pkg::csq_sts_t                sts
);

    localparam int ID_W  = (THREAD_ID_BITS < csq_pkg::TID_W) ? THREAD_ID_BITS : csq_pkg::TID_W;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);
    localparam logic signed [csq_pkg::COUNT_W-1:0] COUNT_ONE = csq_pkg::COUNT_W'(1);

    logic [ID_W-1:0] mem [QUEUE_DEPTH];
    logic [ID_W-1:0] rd_data_reg;

    logic signed [csq_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [csq_pkg::OP_W-1:0] op_reg, op_next;
    logic [ID_W-1:0] tid_reg, tid_next;

    logic                        out_valid_reg, out_valid_next;
    logic [csq_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [ID_W-1:0]             rel_reg, rel_next;
    logic                        woke_reg, woke_next;
    logic                        failed_reg, failed_next;
    logic                        last_reg, last_next;

    logic                        push;
    logic signed [csq_pkg::COUNT_W-1:0] count_inc;
    logic                        out_free;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign out_free  = !out_valid_reg || m_tready;
    assign count_inc = (count_reg < csq_pkg::COUNT_MAX) ? count_reg + COUNT_ONE : count_reg;

    assign sts.out_free    = out_free;
    assign sts.queue_empty = (occ_reg == '0);
    assign sts.op          = op_reg;

    always_comb
    begin
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        op_next        = op_reg;
        tid_next       = tid_reg;
        out_valid_next = out_valid_reg && !m_tready;
        kind_next      = kind_reg;
        rel_next       = rel_reg;
        woke_next      = woke_reg;
        failed_next    = failed_reg;
        last_next      = last_reg;
        push           = 1'b0;

        if (cmd.load_in)
        begin
            op_next  = in_op;
            tid_next = in_tid[ID_W-1:0];
        end

        if (cmd.do_op)
        begin
            out_valid_next = 1'b1;
            woke_next      = 1'b0;
            failed_next    = 1'b0;
            last_next      = 1'b1;
            rel_next       = tid_reg;
            if (op_reg == csq_pkg::OP_WAIT)
            begin
                if (count_reg > 0)
                begin
                    count_next = count_reg - COUNT_ONE;
                    kind_next  = csq_pkg::KIND_GRANTED;
                end
                else if (occ_reg == OCC_FULL)
                begin
                    kind_next = csq_pkg::KIND_FULL;
                end
                else
                begin
                    if (count_reg != csq_pkg::COUNT_MIN)
                    begin
                        count_next = count_reg - COUNT_ONE;
                    end
                    push      = 1'b1;
                    tail_next = next_slot(tail_reg);
                    occ_next  = occ_reg + 1'b1;
                    kind_next = csq_pkg::KIND_BLOCKED;
                end
            end
            else
            begin
                count_next = count_inc;
                kind_next  = csq_pkg::KIND_SIG_DONE;
                if (count_inc <= 0 && occ_reg != '0)
                begin
                    rel_next  = rd_data_reg;
                    woke_next = 1'b1;
                    head_next = next_slot(head_reg);
                    occ_next  = occ_reg - 1'b1;
                end
                else
                begin
                    rel_next = '0;
                end
            end
        end

        if (cmd.drain_pop)
        begin
            out_valid_next = 1'b1;
            kind_next      = csq_pkg::KIND_RELEASED;
            rel_next       = rd_data_reg;
            woke_next      = 1'b0;
            failed_next    = 1'b1;
            last_next      = 1'b0;
            head_next      = next_slot(head_reg);
            occ_next       = occ_reg - 1'b1;
        end

        if (cmd.close_done)
        begin
            out_valid_next = 1'b1;
            kind_next      = csq_pkg::KIND_CLOSED;
            rel_next       = '0;
            woke_next      = 1'b0;
            failed_next    = 1'b0;
            last_next      = 1'b1;
            head_next      = '0;
            tail_next      = '0;
            occ_next       = '0;
        end

        if (cfg_we)
        begin
            count_next = csq_pkg::COUNT_W'(cfg_wdata);
            head_next  = '0;
            tail_next  = '0;
            occ_next   = '0;
        end
    end

    // read address follows the next head so the head entry is ready in time
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= tid_reg;
        end
        rd_data_reg <= mem[head_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            op_reg        <= csq_pkg::OP_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg    <= tid_next;
        kind_reg   <= kind_next;
        rel_reg    <= rel_next;
        woke_reg   <= woke_next;
        failed_reg <= failed_next;
        last_reg   <= last_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign out_kind   = kind_reg;
    assign out_tid    = csq_pkg::TID_W'(rel_reg);
    assign out_woke   = woke_reg;
    assign out_failed = failed_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire

FILE: rtl/counting_semaphore_wait_queue.sv
// counting_semaphore_wait_queue: counting semaphore with a fifo of blocked thread ids
// depends on csq_pkg, csq_ctrl and csq_datapath
// a wait or signal beat is latched, executed once the output register is free, and its result
// beat is registered; a new beat is taken only after the last has executed; a close releases
// one waiter beat per cycle while m_tready holds, from the single read port of the waiter memory
// reset: count, queue pointers and occupancy cleared; waiter memory is not cleared
`default_nettype none

module counting_semaphore_wait_queue
#(
    parameter int QUEUE_DEPTH    = csq_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = csq_pkg::THREAD_ID_BITS_DEF
)
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire  [csq_pkg::CFG_W-1:0]         cfg_wdata,   // initial_count
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [csq_pkg::S_TDATA_W-1:0]     s_tdata,     // thread_id
    input  wire  [csq_pkg::OP_W-1:0]          s_tuser,     // operation
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [csq_pkg::M_TDATA_W-1:0]     m_tdata,     // released_thread, woke_thread, release_failed, zero pad
    output logic [csq_pkg::KIND_W-1:0]        m_tuser,     // result_kind
    output logic                              m_tlast
);

    csq_pkg::csq_cmd_t cmd;
    csq_pkg::csq_sts_t sts;

    logic [csq_pkg::TID_W-1:0] out_tid;
    logic                      out_woke;
    logic                      out_failed;

    csq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    csq_datapath
    #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .THREAD_ID_BITS (THREAD_ID_BITS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_op      (s_tuser),
        .in_tid     (s_tdata),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_kind   (m_tuser),
        .out_tid    (out_tid),
        .out_woke   (out_woke),
        .out_failed (out_failed),
        .out_last   (m_tlast),
        .cmd        (cmd),
        .sts        (sts)
    );

    assign m_tdata = {6'b0, out_failed, out_woke, out_tid};

endmodule

`default_nettype wire
